### hw/rtl/chte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_pkg: shared types and constants of the chained hash table engine
// Table sizes, operation and status codes, the request record and the hash.
// ----------------------------------------------------------------------------
package chte_pkg;
	localparam int Buckets  = 1024;
	localparam int Nodes    = 1024;
	localparam int BktW     = $clog2(Buckets);
	localparam int NodeW    = $clog2(Nodes);
	localparam int PtrW     = NodeW + 1;
	localparam int CntW     = 11;
	localparam int CfgW     = 11;
	localparam logic [PtrW-1:0] EmptyPtr = PtrW'(Nodes);
	localparam logic [31:0] Mix1 = 32'h85ebca6b;
	localparam logic [31:0] Mix2 = 32'hc2b2ae35;

	localparam logic [1:0] OpLookup = 2'd0;
	localparam logic [1:0] OpInsert = 2'd1;
	localparam logic [1:0] OpRemove = 2'd2;
	localparam logic [1:0] OpUnused = 2'd3;

	localparam logic [1:0] StHit  = 2'd0;
	localparam logic [1:0] StMiss = 2'd1;
	localparam logic [1:0] StFull = 2'd2;

	typedef struct packed {
		logic [1:0]      op;
		logic [31:0]     key;
		logic [31:0]     val;
		logic [BktW-1:0] bucket;
	} req_t;
endpackage

### hw/rtl/chte_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_ram: generic single-port RAM
// One write or one read a cycle; read data registered.
// ----------------------------------------------------------------------------
module chte_ram #(
	parameter int Width = 32,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### hw/rtl/chte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_front: hash front end
// Computes fmix32 of the key over five sequential steps and reduces it modulo
// the bucket count by restoring division, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module chte_front import chte_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      op,
	input  logic [31:0]     key,
	input  logic [31:0]     val,
	input  logic [CfgW-1:0] modulus,
	output logic            out_valid,
	input  logic            out_ready,
	output req_t            out_req
);
	typedef enum logic [1:0] {F_IDLE, F_MIX, F_DIV, F_OUT} fstate_t;
	fstate_t        state_q;
	logic [2:0]     mix_step_q;
	logic [5:0]     bit_q;
	logic [31:0]    h_q;
	logic [31:0]    quo_q;
	logic [CfgW:0]  rem_q;
	logic [1:0]     op_q;
	logic [31:0]    key_q;
	logic [31:0]    val_q;
	logic [CfgW-1:0] mod_q;
	logic [CfgW:0]  shifted;

	assign in_ready  = (state_q == F_IDLE);
	assign out_valid = (state_q == F_OUT);
	assign out_req   = '{op: op_q, key: key_q, val: val_q, bucket: rem_q[BktW-1:0]};
	assign shifted   = {rem_q[CfgW-1:0], quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			mix_step_q <= '0;
			bit_q      <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						op_q       <= op;
						key_q      <= key;
						val_q      <= val;
						h_q        <= key;
						// clamp modulus to 1..Buckets
						if (modulus == '0) begin
							mod_q <= CfgW'(1);
						end else if (modulus > CfgW'(Buckets)) begin
							mod_q <= CfgW'(Buckets);
						end else begin
							mod_q <= modulus;
						end
						mix_step_q <= '0;
						state_q    <= F_MIX;
					end
				end
				F_MIX: begin
					case (mix_step_q)
						3'd0: h_q <= h_q ^ (h_q >> 16);
						3'd1: h_q <= h_q * Mix1;
						3'd2: h_q <= h_q ^ (h_q >> 13);
						3'd3: h_q <= h_q * Mix2;
						default: h_q <= h_q ^ (h_q >> 16);
					endcase
					mix_step_q <= mix_step_q + 3'd1;
					if (mix_step_q == 3'd4) begin
						quo_q   <= h_q ^ (h_q >> 16);
						rem_q   <= '0;
						bit_q   <= '0;
						state_q <= F_DIV;
					end
				end
				F_DIV: begin
					if (shifted >= {1'b0, mod_q}) begin
						rem_q <= shifted - {1'b0, mod_q};
					end else begin
						rem_q <= shifted;
					end
					quo_q <= {quo_q[30:0], 1'b0};
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) begin
						state_q <= F_OUT;
					end
				end
				F_OUT: begin
					if (out_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/chte_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_queue: two-entry request queue
// Decouples the hash front end from the table back end.
// ----------------------------------------------------------------------------
module chte_queue import chte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_req,
	output logic out_valid,
	input  logic out_ready,
	output req_t out_req
);
	req_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	assign in_ready  = (fill_q != 2'd2);
	assign out_valid = (fill_q != 2'd0);
	assign out_req   = slot_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### hw/rtl/chte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chte_back: table back end
// Walks the bucket chain through the node memories, updates links, values,
// the free list and the live count, and holds one result in an output register.
// ----------------------------------------------------------------------------
module chte_back import chte_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_req,
	output logic             busy,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       out_status,
	output logic [31:0]      out_value,
	output logic [CntW-1:0]  out_count
);
	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_HEAD_RD, B_HEAD_WAIT, B_NODE_RD, B_NODE_WAIT, B_CHECK,
		B_FREE_RD, B_FREE_WAIT, B_WRITE, B_DONE
	} bstate_t;

	bstate_t         state_q;
	req_t            req_q;
	logic [BktW:0]   clr_q;
	logic [PtrW-1:0] cur_q;
	logic [PtrW-1:0] prev_q;
	logic [NodeW:0]  steps_q;
	logic [PtrW-1:0] hw_q;
	logic [PtrW-1:0] free_q;
	logic [CntW-1:0] live_q;
	logic            res_valid_q;
	logic [1:0]      res_status_q;
	logic [31:0]     res_value_q;
	logic [CntW-1:0] res_count_q;
	logic [1:0]      act_q;
	logic [PtrW-1:0] node_q;
	logic [PtrW-1:0] nxt_q;
	// remove writes the freed node link first, then the predecessor or head
	logic            wr2_q;

	// memory ports
	logic            head_we;
	logic [BktW-1:0] head_addr;
	logic [PtrW-1:0] head_wd;
	logic [PtrW-1:0] head_rd;
	logic            key_we;
	logic            val_we;
	logic            lnk_we;
	logic [NodeW-1:0] node_addr;
	logic [NodeW-1:0] lnk_addr;
	logic [31:0]     key_wd;
	logic [31:0]     val_wd;
	logic [PtrW-1:0] lnk_wd;
	logic [31:0]     key_rd;
	logic [31:0]     val_rd;
	logic [PtrW-1:0] lnk_rd;

	localparam logic [1:0] ActHit = 2'd0, ActNew = 2'd1, ActNone = 2'd2;

	chte_ram #(.Width(PtrW), .Depth(Buckets)) u_heads (
		.clk(clk), .we(head_we), .addr(head_addr), .wdata(head_wd), .rdata(head_rd));
	chte_ram #(.Width(32), .Depth(Nodes)) u_keys (
		.clk(clk), .we(key_we), .addr(node_addr), .wdata(key_wd), .rdata(key_rd));
	chte_ram #(.Width(32), .Depth(Nodes)) u_vals (
		.clk(clk), .we(val_we), .addr(node_addr), .wdata(val_wd), .rdata(val_rd));
	chte_ram #(.Width(PtrW), .Depth(Nodes)) u_links (
		.clk(clk), .we(lnk_we), .addr(lnk_addr), .wdata(lnk_wd), .rdata(lnk_rd));

	assign in_ready   = (state_q == B_IDLE) && !res_valid_q;
	assign busy       = (state_q != B_IDLE) || res_valid_q;
	assign out_valid  = res_valid_q;
	assign out_status = res_status_q;
	assign out_value  = res_value_q;
	assign out_count  = res_count_q;

	always_comb begin
		head_we   = 1'b0;
		head_addr = req_q.bucket;
		head_wd   = EmptyPtr;
		key_we    = 1'b0;
		val_we    = 1'b0;
		lnk_we    = 1'b0;
		node_addr = cur_q[NodeW-1:0];
		lnk_addr  = cur_q[NodeW-1:0];
		key_wd    = req_q.key;
		val_wd    = req_q.val;
		lnk_wd    = EmptyPtr;
		case (state_q)
			B_CLEAR: begin
				head_we   = 1'b1;
				head_addr = clr_q[BktW-1:0];
			end
			B_FREE_RD: begin
				lnk_addr = free_q[NodeW-1:0];
			end
			B_WRITE: begin
				node_addr = node_q[NodeW-1:0];
				lnk_addr  = node_q[NodeW-1:0];
				if (act_q == ActHit && req_q.op == OpInsert) begin
					val_we = 1'b1;
				end else if (act_q == ActHit && req_q.op == OpRemove) begin
					if (!wr2_q) begin
						lnk_we = 1'b1;
						lnk_wd = free_q;
					end else if (prev_q != EmptyPtr) begin
						lnk_we   = 1'b1;
						lnk_addr = prev_q[NodeW-1:0];
						lnk_wd   = nxt_q;
					end else begin
						head_we = 1'b1;
						head_wd = nxt_q;
					end
				end else if (act_q == ActNew) begin
					key_we  = 1'b1;
					val_we  = 1'b1;
					lnk_we  = 1'b1;
					lnk_wd  = nxt_q;
					head_we = 1'b1;
					head_wd = node_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			hw_q        <= '0;
			free_q      <= EmptyPtr;
			live_q      <= '0;
			res_valid_q <= 1'b0;
			wr2_q       <= 1'b0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (BktW+1)'(Buckets - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (in_valid && !res_valid_q) begin
						req_q   <= in_req;
						prev_q  <= EmptyPtr;
						steps_q <= '0;
						wr2_q   <= 1'b0;
						if (in_req.op == OpUnused) begin
							res_status_q <= StMiss;
							res_value_q  <= '0;
							res_count_q  <= live_q;
							res_valid_q  <= 1'b1;
						end else begin
							state_q <= B_HEAD_RD;
						end
					end
				end
				B_HEAD_RD: state_q <= B_HEAD_WAIT;
				B_HEAD_WAIT: begin
					cur_q   <= head_rd;
					nxt_q   <= head_rd;
					state_q <= B_NODE_RD;
				end
				B_NODE_RD: begin
					if (cur_q == EmptyPtr || steps_q == (NodeW+1)'(Nodes)) begin
						state_q <= B_CHECK;
						act_q   <= ActNone;
					end else begin
						state_q <= B_NODE_WAIT;
					end
				end
				B_NODE_WAIT: begin
					if (key_rd == req_q.key) begin
						act_q   <= ActHit;
						node_q  <= cur_q;
						nxt_q   <= lnk_rd;
						res_value_q <= val_rd;
						state_q <= B_CHECK;
					end else begin
						prev_q  <= cur_q;
						cur_q   <= lnk_rd;
						steps_q <= steps_q + 1'b1;
						state_q <= B_NODE_RD;
					end
				end
				B_CHECK: begin
					if (act_q == ActHit) begin
						res_status_q <= StHit;
						state_q      <= B_WRITE;
					end else begin
						res_value_q <= '0;
						if (req_q.op != OpInsert) begin
							res_status_q <= StMiss;
							state_q      <= B_DONE;
						end else if (free_q != EmptyPtr) begin
							node_q  <= free_q;
							state_q <= B_FREE_RD;
						end else if (hw_q != EmptyPtr) begin
							node_q  <= hw_q;
							hw_q    <= hw_q + 1'b1;
							act_q   <= ActNew;
							res_status_q <= StMiss;
							state_q <= B_WRITE;
						end else begin
							res_status_q <= StFull;
							state_q      <= B_DONE;
						end
					end
				end
				B_FREE_RD: state_q <= B_FREE_WAIT;
				B_FREE_WAIT: begin
					free_q       <= lnk_rd;
					act_q        <= ActNew;
					res_status_q <= StMiss;
					state_q      <= B_WRITE;
				end
				B_WRITE: begin
					if (act_q == ActHit && req_q.op == OpRemove) begin
						if (!wr2_q) begin
							wr2_q <= 1'b1;
						end else begin
							free_q <= node_q;
							if (live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
							state_q <= B_DONE;
						end
					end else begin
						if (act_q == ActNew) begin
							live_q <= live_q + 1'b1;
						end
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					res_count_q <= live_q;
					res_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/chained_hash_table_engine.sv
`timescale 1ns / 1ps
// Key-value table with separate chaining over a 1024-node pool. Hashing of an
// accepted request runs five fmix32 steps and a bit-serial modulo, then hands
// the request off; the back end then reads the bucket head, visits the chain
// nodes through registered-read node memories, then checks, updates and
// returns the result. Hashing of the next request overlaps the back end
// through a two-entry queue. After reset the bucket heads are cleared, during
// which requests wait in the front end and the queue.
// Write bucket_count only while the block is idle.
// ----------------------------------------------------------------------------
// chained_hash_table_engine: top level
// Hash front end, request queue and table back end.
// ----------------------------------------------------------------------------
module chained_hash_table_engine import chte_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      operation,
	input  logic [31:0]     key,
	input  logic [31:0]     new_value,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      status,
	output logic [31:0]     found_value,
	output logic [CntW-1:0] entry_count,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CfgW-1:0] cfg_data
);
	logic [CfgW-1:0] bucket_count_q;
	logic            f_valid, f_ready, q_valid, q_ready, b_busy;
	req_t            f_req, q_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= CfgW'(Buckets);
		end else if (cfg_valid) begin
			bucket_count_q <= cfg_data;
		end
	end

	chte_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(operation), .key(key), .val(new_value), .modulus(bucket_count_q),
		.out_valid(f_valid), .out_ready(f_ready), .out_req(f_req));

	chte_queue u_queue (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready),
		.in_req(f_req), .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req));

	chte_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_ready(q_ready),
		.in_req(q_req), .busy(b_busy), .out_valid(out_valid), .out_ready(out_ready),
		.out_status(status), .out_value(found_value), .out_count(entry_count));

	// a result that is not a hit carries a zero value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != StHit |-> found_value == '0)
		else $error("miss result carries a value");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CntW'(Nodes))
		else $error("entry count beyond pool size");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> b_busy)
		else $error("result shown while back end idle");
endmodule
